[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and controller/datapath command types for the rational
// accumulator.
// ----------------------------------------------------------------------------
package rau_pkg;

    // operation codes on the input channel
    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // datapath micro-operations
    localparam logic [3:0] DP_MOV    = 4'd0;
    localparam logic [3:0] DP_NEGIF  = 4'd1;
    localparam logic [3:0] DP_ADD    = 4'd2;
    localparam logic [3:0] DP_SUB    = 4'd3;
    localparam logic [3:0] DP_GCD    = 4'd4;
    localparam logic [3:0] DP_UDIV   = 4'd5;
    localparam logic [3:0] DP_SDIV   = 4'd6;
    localparam logic [3:0] DP_DIVMAG = 4'd7;
    localparam logic [3:0] DP_UMUL   = 4'd8;
    localparam logic [3:0] DP_SMUL   = 4'd9;

    // datapath register selects
    localparam logic [2:0] RG_AN = 3'd0;
    localparam logic [2:0] RG_AD = 3'd1;
    localparam logic [2:0] RG_X  = 3'd2;
    localparam logic [2:0] RG_Y  = 3'd3;
    localparam logic [2:0] RG_N  = 3'd4;
    localparam logic [2:0] RG_D  = 3'd5;
    localparam logic [2:0] RG_G  = 3'd6;
    localparam logic [2:0] RG_T  = 3'd7;

    typedef struct packed {
        logic       start;
        logic       capture;
        logic [3:0] op;
        logic [2:0] src_a;
        logic [2:0] src_b;
        logic [2:0] dst;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic x_zero;
        logic y_zero;
        logic ad_zero;
        logic ovf;
    } t_dp_stat;

endpackage

[rtl/rau_gcd.sv]
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two unsigned words, one subtract or shift step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_g
);

    localparam int unsigned KW = $clog2(WORD_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [WORD_WIDTH-1:0] r_a;
    logic [WORD_WIDTH-1:0] r_b;
    logic [WORD_WIDTH-1:0] r_g;
    logic [KW-1:0]         r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a == '0) begin
                    r_g    <= r_b << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_b == '0) begin
                    r_g    <= r_a << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_a[0] && !r_b[0]) begin
                    // common factor of two
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

[rtl/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_num,
    input  logic [WORD_WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_quo
);

    localparam int unsigned CW = $clog2(WORD_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [WORD_WIDTH-1:0] r_rem;
    logic [WORD_WIDTH-1:0] r_quo;
    logic [WORD_WIDTH-1:0] r_den;
    logic [CW-1:0]         r_cnt;

    logic [WORD_WIDTH:0]   w_sh;
    logic [WORD_WIDTH:0]   w_dif;
    logic                  w_ge;

    assign w_sh  = {r_rem, r_quo[WORD_WIDTH-1]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_dif = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= CW'(WORD_WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_dif[WORD_WIDTH-1:0] : w_sh[WORD_WIDTH-1:0];
                r_quo <= {r_quo[WORD_WIDTH-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/rau_mul.sv]
// ----------------------------------------------------------------------------
// rau_mul
// Shift-add unsigned multiplier with full double-width product.
// ----------------------------------------------------------------------------
module rau_mul #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [WORD_WIDTH-1:0]   i_a,
    input  logic [WORD_WIDTH-1:0]   i_b,
    output logic                    o_done,
    output logic [2*WORD_WIDTH-1:0] o_p
);

    localparam int unsigned CW = $clog2(WORD_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [WORD_WIDTH-1:0] r_a;
    logic [WORD_WIDTH-1:0] r_hi;
    logic [WORD_WIDTH-1:0] r_lo;
    logic [CW-1:0]         r_cnt;
    logic [WORD_WIDTH:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= CW'(WORD_WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[WORD_WIDTH:1];
                r_lo  <= {w_sum[0], r_lo[WORD_WIDTH-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = {r_hi, r_lo};

endmodule

[rtl/rau_dp.sv]
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: accumulator and scratch registers, combinational ALU ops and the
// shared gcd, divide and multiply units.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rau_pkg::t_dp_cmd      i_cmd,
    output rau_pkg::t_dp_stat     o_stat,
    input  logic [WORD_WIDTH-1:0] i_operand_num,
    input  logic [WORD_WIDTH-1:0] i_operand_den,
    output logic [WORD_WIDTH-1:0] o_acc_num,
    output logic [WORD_WIDTH-1:0] o_acc_den
);

    localparam int unsigned W = WORD_WIDTH;
    localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (-v) : v;
    endfunction

    logic [W-1:0] r_an, r_ad, r_x, r_y, r_n, r_d, r_g, r_t;
    logic         r_ovf;
    logic         r_done;
    logic [3:0]   r_op;
    logic [2:0]   r_dst;
    logic         r_neg;
    logic         r_bzero;

    logic [W-1:0]   w_a, w_b;
    logic           w_wr_en;
    logic [2:0]     w_wr_dst;
    logic [W-1:0]   w_wr_data;
    logic           w_ovf_set;
    logic           w_done_n;
    logic           w_gcd_go, w_div_go, w_mul_go;
    logic [W-1:0]   w_u_a, w_u_b;
    logic           w_gcd_done, w_div_done, w_mul_done;
    logic [W-1:0]   w_gcd_g, w_quo;
    logic [2*W-1:0] w_prod;
    logic [W-1:0]   w_sum, w_dif, w_low;

    always_comb begin
        case (i_cmd.src_a)
            rau_pkg::RG_AN: w_a = r_an;
            rau_pkg::RG_AD: w_a = r_ad;
            rau_pkg::RG_X:  w_a = r_x;
            rau_pkg::RG_Y:  w_a = r_y;
            rau_pkg::RG_N:  w_a = r_n;
            rau_pkg::RG_D:  w_a = r_d;
            rau_pkg::RG_G:  w_a = r_g;
            default:        w_a = r_t;
        endcase
        case (i_cmd.src_b)
            rau_pkg::RG_AN: w_b = r_an;
            rau_pkg::RG_AD: w_b = r_ad;
            rau_pkg::RG_X:  w_b = r_x;
            rau_pkg::RG_Y:  w_b = r_y;
            rau_pkg::RG_N:  w_b = r_n;
            rau_pkg::RG_D:  w_b = r_d;
            rau_pkg::RG_G:  w_b = r_g;
            default:        w_b = r_t;
        endcase
    end

    assign w_sum = w_a + w_b;
    assign w_dif = w_a - w_b;
    assign w_low = w_prod[W-1:0];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_dst  = i_cmd.dst;
        w_wr_data = w_a;
        w_ovf_set = 1'b0;
        w_done_n  = 1'b0;
        w_gcd_go  = 1'b0;
        w_div_go  = 1'b0;
        w_mul_go  = 1'b0;
        w_u_a     = mag(w_a);
        w_u_b     = mag(w_b);
        if (i_cmd.start) begin
            case (i_cmd.op)
                rau_pkg::DP_MOV: begin
                    w_wr_en  = 1'b1;
                    w_done_n = 1'b1;
                end
                rau_pkg::DP_NEGIF: begin
                    w_wr_en  = 1'b1;
                    w_done_n = 1'b1;
                    if (w_b[W-1]) begin
                        w_wr_data = -w_a;
                        w_ovf_set = (w_a == SIGN);
                    end
                end
                rau_pkg::DP_ADD: begin
                    w_wr_en   = 1'b1;
                    w_done_n  = 1'b1;
                    w_wr_data = w_sum;
                    w_ovf_set = (w_a[W-1] == w_b[W-1]) && (w_sum[W-1] != w_a[W-1]);
                end
                rau_pkg::DP_SUB: begin
                    w_wr_en   = 1'b1;
                    w_done_n  = 1'b1;
                    w_wr_data = w_dif;
                    w_ovf_set = (w_a[W-1] != w_b[W-1]) && (w_dif[W-1] != w_a[W-1]);
                end
                rau_pkg::DP_GCD: w_gcd_go = 1'b1;
                rau_pkg::DP_UDIV, rau_pkg::DP_SDIV: w_div_go = 1'b1;
                rau_pkg::DP_DIVMAG: begin
                    // divisor of zero or one leaves the value as is
                    if (w_b[W-1:1] == '0) begin
                        w_wr_en  = 1'b1;
                        w_done_n = 1'b1;
                    end else begin
                        w_u_b    = w_b;
                        w_div_go = 1'b1;
                    end
                end
                rau_pkg::DP_UMUL: begin
                    w_u_a    = w_a;
                    w_mul_go = 1'b1;
                end
                rau_pkg::DP_SMUL: w_mul_go = 1'b1;
                default: w_done_n = 1'b1;
            endcase
        end else if (w_gcd_done || w_div_done || w_mul_done) begin
            w_wr_en  = 1'b1;
            w_wr_dst = r_dst;
            w_done_n = 1'b1;
            case (r_op)
                rau_pkg::DP_GCD:    w_wr_data = w_gcd_g;
                rau_pkg::DP_UDIV:   w_wr_data = w_quo;
                rau_pkg::DP_DIVMAG: w_wr_data = r_neg ? (-w_quo) : w_quo;
                rau_pkg::DP_SDIV: begin
                    if (r_bzero) begin
                        w_wr_data = '0;
                    end else begin
                        w_wr_data = r_neg ? (-w_quo) : w_quo;
                        w_ovf_set = !r_neg && (w_quo == SIGN);
                    end
                end
                rau_pkg::DP_UMUL: begin
                    w_wr_data = w_low;
                    w_ovf_set = (w_prod[2*W-1:W-1] != '0);
                end
                rau_pkg::DP_SMUL: begin
                    w_wr_data = r_neg ? (-w_low) : w_low;
                    if (r_neg) begin
                        w_ovf_set = (w_prod[2*W-1:W] != '0) ||
                                    (w_prod[W-1] && (w_prod[W-2:0] != '0));
                    end else begin
                        w_ovf_set = (w_prod[2*W-1:W-1] != '0);
                    end
                end
                default: w_wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_an   <= '0;
            r_ad   <= {{(W-1){1'b0}}, 1'b1};
            r_ovf  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_done_n;
            if (i_cmd.capture) begin
                r_x   <= i_operand_num;
                r_y   <= i_operand_den;
                r_ovf <= 1'b0;
            end else if (w_ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.start) begin
                r_op    <= i_cmd.op;
                r_dst   <= i_cmd.dst;
                r_bzero <= (w_b == '0);
                if (i_cmd.op == rau_pkg::DP_DIVMAG) begin
                    r_neg <= w_a[W-1];
                end else begin
                    r_neg <= w_a[W-1] ^ w_b[W-1];
                end
            end
            if (w_wr_en) begin
                case (w_wr_dst)
                    rau_pkg::RG_AN: r_an <= w_wr_data;
                    rau_pkg::RG_AD: r_ad <= w_wr_data;
                    rau_pkg::RG_X:  r_x  <= w_wr_data;
                    rau_pkg::RG_Y:  r_y  <= w_wr_data;
                    rau_pkg::RG_N:  r_n  <= w_wr_data;
                    rau_pkg::RG_D:  r_d  <= w_wr_data;
                    rau_pkg::RG_G:  r_g  <= w_wr_data;
                    default:        r_t  <= w_wr_data;
                endcase
            end
        end
    end

    rau_gcd #(.WORD_WIDTH(W)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_go),
        .i_a     (w_u_a),
        .i_b     (w_u_b),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    rau_div #(.WORD_WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_u_a),
        .i_den   (w_u_b),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    rau_mul #(.WORD_WIDTH(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (w_u_a),
        .i_b     (w_u_b),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    assign o_stat.done    = r_done;
    assign o_stat.x_zero  = (r_x == '0);
    assign o_stat.y_zero  = (r_y == '0);
    assign o_stat.ad_zero = (r_ad == '0);
    assign o_stat.ovf     = r_ovf;
    assign o_acc_num      = r_an;
    assign o_acc_den      = r_ad;

endmodule

[rtl/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: takes a transaction, checks the zero cases, steps the datapath
// through the micro-program of the operation and presents the result.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_op,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output rau_pkg::t_dp_cmd  o_cmd,
    input  rau_pkg::t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] dst;
        logic       last;
    } t_ustep;

    function automatic t_ustep mk(input logic [3:0] po, input logic [2:0] pa,
                                  input logic [2:0] pb, input logic [2:0] pd,
                                  input logic pl);
        t_ustep s;
        s.op   = po;
        s.a    = pa;
        s.b    = pb;
        s.dst  = pd;
        s.last = pl;
        return s;
    endfunction

    // micro-program: operation-specific head, then the common reduce/commit tail
    function automatic t_ustep ustep(input logic [2:0] op, input logic [3:0] pc);
        t_ustep     s;
        logic [2:0] rn2;
        logic [2:0] rd2;
        logic [3:0] tp;
        logic       head;
        rn2  = (op == rau_pkg::OP_DIV) ? rau_pkg::RG_Y : rau_pkg::RG_X;
        rd2  = (op == rau_pkg::OP_DIV) ? rau_pkg::RG_X : rau_pkg::RG_Y;
        head = (op == rau_pkg::OP_LOAD) ? (pc < 4'd2) : (pc < 4'd8);
        tp   = (op == rau_pkg::OP_LOAD) ? (pc - 4'd2) : (pc - 4'd8);
        s    = mk(rau_pkg::DP_MOV, rau_pkg::RG_N, rau_pkg::RG_N, rau_pkg::RG_N, 1'b1);
        if (head) begin
            if (op == rau_pkg::OP_LOAD) begin
                case (pc)
                    4'd0:    s = mk(rau_pkg::DP_MOV, rau_pkg::RG_X, rau_pkg::RG_X,
                                    rau_pkg::RG_N, 1'b0);
                    default: s = mk(rau_pkg::DP_MOV, rau_pkg::RG_Y, rau_pkg::RG_Y,
                                    rau_pkg::RG_D, 1'b0);
                endcase
            end else if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
                case (pc)
                    4'd0: s = mk(rau_pkg::DP_GCD, rau_pkg::RG_AD, rau_pkg::RG_Y,
                                 rau_pkg::RG_G, 1'b0);
                    4'd1: s = mk(rau_pkg::DP_UDIV, rau_pkg::RG_AD, rau_pkg::RG_G,
                                 rau_pkg::RG_T, 1'b0);
                    4'd2: s = mk(rau_pkg::DP_UMUL, rau_pkg::RG_T, rau_pkg::RG_Y,
                                 rau_pkg::RG_D, 1'b0);
                    4'd3: s = mk(rau_pkg::DP_SDIV, rau_pkg::RG_D, rau_pkg::RG_AD,
                                 rau_pkg::RG_T, 1'b0);
                    4'd4: s = mk(rau_pkg::DP_SMUL, rau_pkg::RG_AN, rau_pkg::RG_T,
                                 rau_pkg::RG_N, 1'b0);
                    4'd5: s = mk(rau_pkg::DP_SDIV, rau_pkg::RG_D, rau_pkg::RG_Y,
                                 rau_pkg::RG_T, 1'b0);
                    4'd6: s = mk(rau_pkg::DP_SMUL, rau_pkg::RG_X, rau_pkg::RG_T,
                                 rau_pkg::RG_T, 1'b0);
                    default: s = mk((op == rau_pkg::OP_SUB) ? rau_pkg::DP_SUB
                                                             : rau_pkg::DP_ADD,
                                    rau_pkg::RG_N, rau_pkg::RG_T, rau_pkg::RG_N, 1'b0);
                endcase
            end else begin
                // cross-cancel before the products
                case (pc)
                    4'd0: s = mk(rau_pkg::DP_GCD, rau_pkg::RG_AN, rd2,
                                 rau_pkg::RG_G, 1'b0);
                    4'd1: s = mk(rau_pkg::DP_DIVMAG, rau_pkg::RG_AN, rau_pkg::RG_G,
                                 rau_pkg::RG_N, 1'b0);
                    4'd2: s = mk(rau_pkg::DP_DIVMAG, rd2, rau_pkg::RG_G, rd2, 1'b0);
                    4'd3: s = mk(rau_pkg::DP_GCD, rau_pkg::RG_AD, rn2,
                                 rau_pkg::RG_G, 1'b0);
                    4'd4: s = mk(rau_pkg::DP_DIVMAG, rau_pkg::RG_AD, rau_pkg::RG_G,
                                 rau_pkg::RG_D, 1'b0);
                    4'd5: s = mk(rau_pkg::DP_DIVMAG, rn2, rau_pkg::RG_G, rn2, 1'b0);
                    4'd6: s = mk(rau_pkg::DP_SMUL, rau_pkg::RG_N, rn2,
                                 rau_pkg::RG_N, 1'b0);
                    default: s = mk(rau_pkg::DP_SMUL, rau_pkg::RG_D, rd2,
                                    rau_pkg::RG_D, 1'b0);
                endcase
            end
        end else begin
            case (tp)
                4'd0: s = mk(rau_pkg::DP_NEGIF, rau_pkg::RG_N, rau_pkg::RG_D,
                             rau_pkg::RG_N, 1'b0);
                4'd1: s = mk(rau_pkg::DP_NEGIF, rau_pkg::RG_D, rau_pkg::RG_D,
                             rau_pkg::RG_D, 1'b0);
                4'd2: s = mk(rau_pkg::DP_GCD, rau_pkg::RG_N, rau_pkg::RG_D,
                             rau_pkg::RG_G, 1'b0);
                4'd3: s = mk(rau_pkg::DP_DIVMAG, rau_pkg::RG_N, rau_pkg::RG_G,
                             rau_pkg::RG_N, 1'b0);
                4'd4: s = mk(rau_pkg::DP_DIVMAG, rau_pkg::RG_D, rau_pkg::RG_G,
                             rau_pkg::RG_D, 1'b0);
                4'd5: s = mk(rau_pkg::DP_MOV, rau_pkg::RG_N, rau_pkg::RG_N,
                             rau_pkg::RG_AN, 1'b0);
                default: s = mk(rau_pkg::DP_MOV, rau_pkg::RG_D, rau_pkg::RG_D,
                                rau_pkg::RG_AD, 1'b1);
            endcase
        end
        return s;
    endfunction

    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [3:0] r_pc, n_pc;
    logic [1:0] r_status, n_status;
    t_ustep     w_step;

    assign w_step = ustep(r_op, r_pc);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_pc          = r_pc;
        n_status      = r_status;
        o_cmd.start   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.op      = w_step.op;
        o_cmd.src_a   = w_step.a;
        o_cmd.src_b   = w_step.b;
        o_cmd.dst     = w_step.dst;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = i_op;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_pc = '0;
                if (r_op > rau_pkg::OP_DIV) begin
                    n_status = rau_pkg::ST_OK;
                    n_state  = S_OUT;
                end else if (i_stat.y_zero ||
                             (r_op == rau_pkg::OP_DIV && i_stat.x_zero) ||
                             (r_op != rau_pkg::OP_LOAD && i_stat.ad_zero)) begin
                    n_status = rau_pkg::ST_ZERO;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    if (w_step.last) begin
                        n_status = i_stat.ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
                        n_state  = S_OUT;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= rau_pkg::OP_LOAD;
            r_pc     <= '0;
            r_status <= rau_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_pc     <= n_pc;
            r_status <= n_status;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_status = r_status;

endmodule

[rtl/rational_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// rational_accumulator_unit
// Exact fraction accumulator: load/add/subtract/multiply/divide with gcd
// reduction, zero-denominator and overflow status.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_op, i_operand_num, i_operand_den
// output   out        o_valid / i_stall    o_result_num, o_result_den, o_status
//
// One transaction at a time. Each op runs a fixed micro-program (9 steps for
// load, 15 for the others) on one shared binary gcd, one restoring divider
// and one shift-add multiplier. Synchronous reset puts the accumulator at
// 0/1. The result is held while i_stall is high and o_stall stays high until
// it is taken.
// ----------------------------------------------------------------------------
module rational_accumulator_unit #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_operand_num,
    input  logic [63:0] i_operand_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_num,
    output logic [62:0] o_result_den,
    output logic [1:0]  o_status
);

    rau_pkg::t_dp_cmd  w_cmd;
    rau_pkg::t_dp_stat w_stat;

    logic        [WORD_WIDTH-1:0] w_acc_num;
    logic        [WORD_WIDTH-1:0] w_acc_den;
    logic signed [WORD_WIDTH-1:0] w_num_s;
    logic signed [WORD_WIDTH-1:0] w_den_s;
    logic        [63:0]           w_den_ext;

    rau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    rau_dp #(.WORD_WIDTH(WORD_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operand_num (i_operand_num[WORD_WIDTH-1:0]),
        .i_operand_den (i_operand_den[WORD_WIDTH-1:0]),
        .o_acc_num     (w_acc_num),
        .o_acc_den     (w_acc_den)
    );

    assign w_num_s      = w_acc_num;
    assign w_den_s      = w_acc_den;
    assign o_result_num = 64'(w_num_s);
    assign w_den_ext    = 64'(w_den_s);
    assign o_result_den = w_den_ext[62:0];

endmodule

[rtl/rau_checker.sv]
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [2:0]  i_op,
    input logic [63:0] i_operand_num,
    input logic [63:0] i_operand_den,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_result_num,
    input logic [62:0] o_result_den,
    input logic [1:0]  o_status
);

    // a pending result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_num) &&
                               $stable(o_result_den) && $stable(o_status))
        else $error("result changed while stalled");

    // no new transaction while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // an accepted transaction never has its result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid && o_stall)
        else $error("result too early");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == rau_pkg::ST_OK || o_status == rau_pkg::ST_ZERO ||
                     o_status == rau_pkg::ST_OVF))
        else $error("bad status code");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind rational_accumulator_unit rau_checker u_rau_checker (.*);

[bench/rational_accumulator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_accumulator_unit_tb
// Self-checking bench for the fraction accumulator. A directed table covers
// reset state, operand extremes, zero denominators, divide by zero, overflow
// wrap and unused op codes. About 550 random transactions follow, mostly
// small fractions with some full-width noise. Every result is compared with
// a local model of the gcd-reduced accumulator or with a row's typed result.
// Random idle and stall bursts are applied on both channels.
// ----------------------------------------------------------------------------
module rational_accumulator_unit_tb;

    localparam int          NUM_RANDOM = 550;
    localparam int          CALM_TAIL  = 60;
    localparam int          WD_LIMIT   = 20000;
    localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS    = 64'h7fff_ffff_ffff_ffff;
    localparam logic [2:0]  OP_UNUSED5 = 3'd5;
    localparam logic [2:0]  OP_UNUSED7 = 3'd7;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic [1:0]  st;
    } t_frac_result;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] num;
        logic [63:0] den;
        bit          typed;
        logic [63:0] exp_num;
        logic [62:0] exp_den;
        logic [1:0]  exp_st;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_op = '0;
    logic [63:0] i_operand_num = '0;
    logic [63:0] i_operand_den = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_num;
    logic [62:0] o_result_den;
    logic [1:0]  o_status;

    rational_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_operand_num (i_operand_num),
        .i_operand_den (i_operand_den),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_num  (o_result_num),
        .o_result_den  (o_result_den),
        .o_status      (o_status)
    );

    always #1 i_clk = ~i_clk;

    t_frac_result expected_results[$];
    int           mismatch_count = 0;
    bit           idling_on = 1'b1;
    int           idle_cycles = 0;

    // ---------------- accumulator model ----------------
    logic [63:0] model_num = 64'd0;
    logic [63:0] model_den = 64'd1;
    bit          ovf_flag;

    function automatic bit is_neg(logic [63:0] v);
        return v[63];
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] negate_w(logic [63:0] v);
        if (v == SIGN_BIT) ovf_flag = 1'b1;
        return -v;
    endfunction

    function automatic logic [63:0] gcd_u(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] apply_sign(bit neg, logic [63:0] m);
        if (m > (neg ? SIGN_BIT : MAX_POS)) ovf_flag = 1'b1;
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] mul_w(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, lim;
        ma  = magnitude(a);
        mb  = magnitude(b);
        lim = (is_neg(a) != is_neg(b)) ? SIGN_BIT : MAX_POS;
        if (ma != 0 && mb > lim / ma) ovf_flag = 1'b1;
        return a * b;
    endfunction

    function automatic logic [63:0] add_w(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) ovf_flag = 1'b1;
        return r;
    endfunction

    function automatic logic [63:0] sub_w(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) ovf_flag = 1'b1;
        return r;
    endfunction

    function automatic logic [63:0] div_by_mag(logic [63:0] a, logic [63:0] m);
        if (m == 0) return a;
        return apply_sign(is_neg(a), magnitude(a) / m);
    endfunction

    function automatic logic [63:0] div_signed(logic [63:0] a, logic [63:0] b);
        logic [63:0] mb;
        mb = magnitude(b);
        if (mb == 0) return 64'd0;
        return apply_sign(is_neg(a) != is_neg(b), magnitude(a) / mb);
    endfunction

    task automatic reduce_frac(inout logic [63:0] n, inout logic [63:0] d);
        logic [63:0] g;
        if (is_neg(d)) begin
            n = negate_w(n);
            d = negate_w(d);
        end
        g = gcd_u(magnitude(n), magnitude(d));
        if (g > 1) begin
            n = div_by_mag(n, g);
            d = div_by_mag(d, g);
        end
    endtask

    // add/subtract over the lcm of the two denominators
    task automatic add_sub_frac(logic [63:0] n2, logic [63:0] d2, bit sub);
        logic [63:0] m1, m2, g, q, nd, a, b, n;
        m1 = magnitude(model_den);
        m2 = magnitude(d2);
        g  = gcd_u(m1, m2);
        if (g == 0) g = 1;
        q = m1 / g;
        if (q != 0 && m2 > MAX_POS / q) ovf_flag = 1'b1;
        nd = q * m2;
        a  = mul_w(model_num, div_signed(nd, model_den));
        b  = mul_w(n2, div_signed(nd, d2));
        n  = sub ? sub_w(a, b) : add_w(a, b);
        reduce_frac(n, nd);
        model_num = n;
        model_den = nd;
    endtask

    // cross-cancel before the product
    task automatic mul_frac(logic [63:0] n2, logic [63:0] d2);
        logic [63:0] r, n1, d1, n, d;
        r  = gcd_u(magnitude(model_num), magnitude(d2));
        n1 = div_by_mag(model_num, r);
        d2 = div_by_mag(d2, r);
        r  = gcd_u(magnitude(model_den), magnitude(n2));
        d1 = div_by_mag(model_den, r);
        n2 = div_by_mag(n2, r);
        n  = mul_w(n1, n2);
        d  = mul_w(d1, d2);
        reduce_frac(n, d);
        model_num = n;
        model_den = d;
    endtask

    task automatic predict_fraction(logic [2:0] op, logic [63:0] n2, logic [63:0] d2,
                                    output t_frac_result res);
        logic [1:0] st;
        st = rau_pkg::ST_OK;
        ovf_flag = 1'b0;
        if (op <= rau_pkg::OP_DIV) begin
            if (d2 == 0 || (op == rau_pkg::OP_DIV && n2 == 0) ||
                (op != rau_pkg::OP_LOAD && model_den == 0))
            begin
                st = rau_pkg::ST_ZERO;
            end else begin
                case (op)
                    rau_pkg::OP_LOAD: begin
                        reduce_frac(n2, d2);
                        model_num = n2;
                        model_den = d2;
                    end
                    rau_pkg::OP_ADD: add_sub_frac(n2, d2, 1'b0);
                    rau_pkg::OP_SUB: add_sub_frac(n2, d2, 1'b1);
                    rau_pkg::OP_MUL: mul_frac(n2, d2);
                    default:         mul_frac(d2, n2);
                endcase
                st = ovf_flag ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
            end
        end
        res.num = model_num;
        res.den = model_den[62:0];
        res.st  = st;
    endtask

    // ---------------- stimulus ----------------
    function automatic logic [63:0] rand_field(bit for_den);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 64'($signed($urandom_range(0, 40)) - 20);
            5:       return for_den ? 64'($urandom_range(1, 12)) : 64'd0;
            6:       return {$urandom, $urandom};
            7:       return $urandom_range(0, 1) ? SIGN_BIT : MAX_POS;
            8:       return 64'(signed'(16'($urandom)));
            default: return 64'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [63:0] n, logic [63:0] d,
                             bit typed, t_frac_result typed_res);
        t_frac_result res;
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_operand_num <= n;
        i_operand_den <= d;
        do @(posedge i_clk); while (o_stall);
        predict_fraction(op, n, d, res);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    t_dir_row dir_rows[$];

    task automatic add_row(logic [2:0] op, logic [63:0] n, logic [63:0] d, bit typed,
                           logic [63:0] en = 0, logic [62:0] ed = 0, logic [1:0] es = 0);
        t_dir_row r;
        r = '{op, n, d, typed, en, ed, es};
        dir_rows.push_back(r);
    endtask

    initial begin
        t_frac_result tr;
        logic [2:0] op;
        add_row(OP_UNUSED5, 64'd3, 64'd7, 1, 64'd0, 63'd1, rau_pkg::ST_OK);
        add_row(rau_pkg::OP_ADD, 64'd1, 64'd0, 1, 64'd0, 63'd1, rau_pkg::ST_ZERO);
        add_row(rau_pkg::OP_LOAD, 64'd6, -64'd4, 0);
        add_row(rau_pkg::OP_ADD, 64'd1, 64'd3, 0);
        add_row(rau_pkg::OP_SUB, 64'd5, 64'd6, 0);
        add_row(rau_pkg::OP_MUL, -64'd4, 64'd9, 0);
        add_row(rau_pkg::OP_DIV, 64'd0, 64'd5, 0);
        add_row(rau_pkg::OP_DIV, 64'd3, -64'd7, 0);
        add_row(rau_pkg::OP_LOAD, MAX_POS, 64'd1, 1, MAX_POS, 63'd1, rau_pkg::ST_OK);
        add_row(rau_pkg::OP_LOAD, SIGN_BIT, 64'd1, 1, SIGN_BIT, 63'd1, rau_pkg::ST_OK);
        // negating the most negative denominator wraps
        add_row(rau_pkg::OP_LOAD, 64'd1, SIGN_BIT, 1, '1, 63'd0, rau_pkg::ST_OVF);
        add_row(rau_pkg::OP_ADD, 64'd1, 64'd1, 0);
        add_row(rau_pkg::OP_LOAD, 64'd0, 64'd5, 1, 64'd0, 63'd1, rau_pkg::ST_OK);
        add_row(rau_pkg::OP_LOAD, MAX_POS, 64'd1, 0);
        add_row(rau_pkg::OP_MUL, MAX_POS, MAX_POS, 0);
        add_row(rau_pkg::OP_LOAD, 64'd1, 64'd2, 0);
        add_row(rau_pkg::OP_MUL, SIGN_BIT, 64'd1, 0);
        add_row(OP_UNUSED7, '1, '1, 0);
        add_row(rau_pkg::OP_LOAD, 64'd3, 64'd0, 0);
        // wrapped product leaves a zero accumulator denominator
        add_row(rau_pkg::OP_LOAD, 64'd1, 64'h1_0000_0000, 0);
        add_row(rau_pkg::OP_MUL, 64'd1, 64'h1_0000_0000, 0);
        add_row(rau_pkg::OP_ADD, 64'd1, 64'd1, 0);
        add_row(rau_pkg::OP_DIV, 64'd2, 64'd3, 0);
        add_row(rau_pkg::OP_LOAD, 64'd0, 64'd1, 1, 64'd0, 63'd1, rau_pkg::ST_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            tr = '{dir_rows[k].exp_num, dir_rows[k].exp_den, dir_rows[k].exp_st};
            send_item(dir_rows[k].op, dir_rows[k].num, dir_rows[k].den,
                      dir_rows[k].typed, tr);
        end

        // hold the sender until the directed part has drained
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);

        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k == NUM_RANDOM - CALM_TAIL) idling_on = 1'b0;
            case ($urandom_range(0, 31))
                0:       op = 3'($urandom_range(5, 7));
                1, 2, 3: op = rau_pkg::OP_LOAD;
                default: op = 3'($urandom_range(0, 4));
            endcase
            send_item(op, rand_field(0), rand_field(1), 0, tr);
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------- result checking and stall ----------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_frac_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: num=%h den=%h st=%0d",
                             o_result_num, o_result_den, o_status);
            end else begin
                e = expected_results.pop_front();
                if (o_result_num !== e.num || o_result_den !== e.den || o_status !== e.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp num=%h den=%h st=%0d got num=%h den=%h st=%0d",
                                 e.num, e.den, e.st, o_result_num, o_result_den, o_status);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
